### design/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActionW = 3;
  localparam int unsigned CapW    = 4;
  localparam logic [CapW-1:0] CapReset = 4'd5;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_REAR  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_REAR   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_TRAVERSE   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_REAR,
    DP_PUSH_FRONT,
    DP_POP_REAR,
    DP_POP_FRONT,
    DP_WALK_START,
    DP_WALK_NEXT
  } dp_op_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_STATUS,
    RES_READ
  } res_sel_e;

  typedef struct packed {
    dp_op_e   op;
    res_sel_e res;
    status_e  status;
    logic     walk;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_last;
  } stat_t;

endpackage

### design/cdq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_in_if
// Request channel: action and value with valid/ready.
// ----------------------------------------------------------------------------
interface cdq_in_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ActionW-1:0]       action;
  logic signed [DataW-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

### design/cdq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_out_if
// Result channel: status, data and last with valid/ready.
// ----------------------------------------------------------------------------
interface cdq_out_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DataW-1:0]  data;
  logic                     last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

### design/cdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_datapath
// Slot memory, front/rear pointers, capacity register, walk counter and
// result register.
// ----------------------------------------------------------------------------
module cdq_datapath import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CapW-1:0]         cfg_wdata_i,
  input  logic signed [DataW-1:0] in_value_i,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  output logic [1:0]              out_status_o,
  output logic signed [DataW-1:0] out_data_o,
  output logic                    out_last_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [IW-1:0] step_up(logic [IW-1:0] i, logic [CW-1:0] c);
    logic [CW-1:0] nx;
    nx = CW'(i) + CW'(1);
    return (nx >= c) ? '0 : IW'(nx);
  endfunction

  function automatic logic [IW-1:0] step_down(logic [IW-1:0] i, logic [CW-1:0] c);
    return (i == '0 || CW'(i) >= c) ? IW'(c - CW'(1)) : i - IW'(1);
  endfunction

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;

  logic [CapW-1:0] cap_q, cap_d;
  logic [IW-1:0]   front_q, front_d;
  logic [IW-1:0]   rear_q, rear_d;
  logic            empty_q, empty_d;
  logic [IW-1:0]   walk_q, walk_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic [1:0]              status_q;
  logic signed [DataW-1:0] data_q;
  logic                    last_q;

  logic [CW-1:0] cap_eff;
  logic [IW-1:0] front_up, front_dn, rear_up, rear_dn, walk_up;
  logic          full, fin;
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign front_up = step_up(front_q, cap_eff);
  assign front_dn = step_down(front_q, cap_eff);
  assign rear_up  = step_up(rear_q, cap_eff);
  assign rear_dn  = step_down(rear_q, cap_eff);
  assign walk_up  = step_up(walk_q, cap_eff);
  assign full     = !empty_q && (rear_up == front_q);
  assign fin      = (walk_q == rear_q) || ((cnt_q + CW'(1)) == cap_eff);

  always_comb begin
    cap_d   = cap_q;
    front_d = front_q;
    rear_d  = rear_q;
    empty_d = empty_q;
    walk_d  = walk_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    rd_en   = 1'b0;
    rd_addr = front_q;
    case (cmd_i.op)
      DP_PUSH_REAR: begin
        wr_en = 1'b1;
        if (empty_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
        end else begin
          rear_d  = rear_up;
          wr_addr = rear_up;
        end
      end
      DP_PUSH_FRONT: begin
        wr_en = 1'b1;
        if (empty_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
        end else begin
          front_d = front_dn;
          wr_addr = front_dn;
        end
      end
      DP_POP_REAR: begin
        rd_en   = 1'b1;
        rd_addr = rear_q;
        if (front_q == rear_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b1;
        end else begin
          rear_d = rear_dn;
        end
      end
      DP_POP_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = front_q;
        if (front_q == rear_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b1;
        end else begin
          front_d = front_up;
        end
      end
      DP_WALK_START: begin
        rd_en   = 1'b1;
        rd_addr = front_q;
        walk_d  = front_q;
        cnt_d   = '0;
      end
      DP_WALK_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = walk_up;
        walk_d  = walk_up;
        cnt_d   = cnt_q + CW'(1);
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      cap_d   = cfg_wdata_i;
      front_d = '0;
      rear_d  = '0;
      empty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
      walk_q  <= '0;
      cnt_q   <= '0;
    end else begin
      cap_q   <= cap_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      walk_q  <= walk_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.res)
      RES_STATUS: begin
        status_q <= cmd_i.status;
        data_q   <= '0;
        last_q   <= 1'b1;
      end
      RES_READ: begin
        status_q <= ST_OK;
        data_q   <= rdata_q;
        last_q   <= cmd_i.walk ? fin : 1'b1;
      end
      default: ;
    endcase
  end

  assign stat_o.empty    = empty_q;
  assign stat_o.full     = full;
  assign stat_o.out_last = last_q;
  assign out_status_o    = status_q;
  assign out_data_o      = data_q;
  assign out_last_o      = last_q;

endmodule

### design/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: decodes actions, steps memory reads and holds each result
// until its transfer.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [ActionW-1:0] in_action_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  stat_t              stat_i,
  output cmd_t               cmd_o
);

  state_e state_q, state_d;
  logic   walk_q, walk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '{op: DP_NONE, res: RES_NONE, status: ST_OK, walk: 1'b0};
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_action_i)
            ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
              state_d    = S_RESP;
              cmd_o.res  = RES_STATUS;
              if (stat_i.full) begin
                cmd_o.status = ST_OVERFLOW;
              end else begin
                cmd_o.status = ST_OK;
                cmd_o.op     = (in_action_i == ACT_PUSH_REAR) ? DP_PUSH_REAR
                                                              : DP_PUSH_FRONT;
              end
            end
            ACT_POP_REAR, ACT_POP_FRONT: begin
              walk_d = 1'b0;
              if (stat_i.empty) begin
                state_d      = S_RESP;
                cmd_o.res    = RES_STATUS;
                cmd_o.status = ST_UNDERFLOW;
              end else begin
                state_d  = S_READ;
                cmd_o.op = (in_action_i == ACT_POP_REAR) ? DP_POP_REAR : DP_POP_FRONT;
              end
            end
            ACT_TRAVERSE: begin
              walk_d = 1'b0;
              if (stat_i.empty) begin
                state_d      = S_RESP;
                cmd_o.res    = RES_STATUS;
                cmd_o.status = ST_UNDERFLOW;
              end else begin
                walk_d   = 1'b1;
                state_d  = S_READ;
                cmd_o.op = DP_WALK_START;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.res  = RES_READ;
        cmd_o.walk = walk_q;
        state_d    = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (walk_q && !stat_i.out_last) begin
            cmd_o.op = DP_WALK_NEXT;
            state_d  = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/circular_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue in a circular slot memory of DEPTH entries.
// ----------------------------------------------------------------------------
// Request channel in_i carries action (push rear/front, pop rear/front,
// traverse) and value; result channel out_o carries status, data and last.
// Each request gives one result, except traverse on a non-empty deque, which
// gives one result per stored entry from front to rear with last set on the
// final one. Actions 5 to 7 are taken and give nothing.
// Push, overflow and underflow: result valid in the cycle after the transfer.
// Pop and each traverse entry: the slot read goes through the slot memory's
// registered read port and then the result register before the result is
// valid. A new request is taken the cycle after the last result transfer,
// so no request is taken while a result is pending.
// A stalled receiver holds the result register and the sequencer in place.
// Reset empties the deque and sets capacity to 5; slot contents are kept.
// cfg_we_i writes capacity (used as 1..DEPTH) and empties the deque; write
// only while idle.
// ----------------------------------------------------------------------------
module circular_deque_top import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  cdq_in_if.sink          in_i,
  cdq_out_if.source       out_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready, out_valid;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_value_i   (in_i.value),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_status_o (out_o.status),
    .out_data_o   (out_o.data),
    .out_last_o   (out_o.last)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
